/* hw/rtl/png_unf_pkg.sv */
// shared types and constants of the png scanline unfilter
package png_unf_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BPP       = 1'd1;

    // png filter type codes
    typedef logic [2:0] t_filter;
    localparam t_filter FLT_NONE  = 3'd0;
    localparam t_filter FLT_SUB   = 3'd1;
    localparam t_filter FLT_UP    = 3'd2;
    localparam t_filter FLT_AVG   = 3'd3;
    localparam t_filter FLT_PAETH = 3'd4;

    // operation carried by an item into the reconstruct stage
    typedef logic [1:0] t_op;
    localparam t_op OP_CLR  = 2'd0;
    localparam t_op OP_DATA = 2'd1;
    localparam t_op OP_ERR  = 2'd2;

    typedef struct packed {
        t_op        op;
        t_filter    filter;
        logic [1:0] ch;
        logic       last;
        logic       first_row;
    } t_item;

endpackage

/* hw/rtl/png_unf_if.sv */
// valid/ready channel interfaces of the png scanline unfilter

interface png_unf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;
    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface png_unf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic [1:0] channel;
    logic       end_of_row;
    logic       bad_filter;
    modport source (output valid, output pixel_byte, output channel, output end_of_row,
                    output bad_filter, input ready);
    modport sink   (input valid, input pixel_byte, input channel, input end_of_row,
                    input bad_filter, output ready);
endinterface

interface png_unf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [png_unf_pkg::CFG_IDX_W-1:0]   index;
    logic [png_unf_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/png_unf_pred.sv */
// filter predictor: none, sub, up, average and paeth
module png_unf_pred (
    input  png_unf_pkg::t_filter i_filter,
    input  logic [7:0]           i_a,
    input  logic [7:0]           i_b,
    input  logic [7:0]           i_c,
    output logic [7:0]           o_pred
);

    logic [8:0]        w_sum;
    logic signed [9:0] w_pa;
    logic signed [9:0] w_pb;
    logic signed [9:0] w_pc;
    logic [9:0]        w_da;
    logic [9:0]        w_db;
    logic [9:0]        w_dc;
    logic [7:0]        w_paeth;

    assign w_sum = {1'b0, i_a} + {1'b0, i_b};

    // p - a = b - c, p - b = a - c, p - c = a + b - 2c
    assign w_pa = $signed({2'b00, i_b}) - $signed({2'b00, i_c});
    assign w_pb = $signed({2'b00, i_a}) - $signed({2'b00, i_c});
    assign w_pc = w_pa + w_pb;
    assign w_da = w_pa[9] ? 10'(-w_pa) : 10'(w_pa);
    assign w_db = w_pb[9] ? 10'(-w_pb) : 10'(w_pb);
    assign w_dc = w_pc[9] ? 10'(-w_pc) : 10'(w_pc);

    always_comb begin
        if (w_da <= w_db && w_da <= w_dc) begin
            w_paeth = i_a;
        end else if (w_db <= w_dc) begin
            w_paeth = i_b;
        end else begin
            w_paeth = i_c;
        end
    end

    always_comb begin
        case (i_filter)
            png_unf_pkg::FLT_SUB:   o_pred = i_a;
            png_unf_pkg::FLT_UP:    o_pred = i_b;
            png_unf_pkg::FLT_AVG:   o_pred = w_sum[8:1];
            png_unf_pkg::FLT_PAETH: o_pred = w_paeth;
            default:                o_pred = 8'd0;
        endcase
    end

endmodule

/* hw/rtl/png_scanline_unfilter.sv */
// PNG scanline unfilter: takes one filtered byte per transfer, the filter type byte first
// in each row, and returns reconstructed R, G, B bytes (alpha dropped). Sustained rate is
// one byte per clock while the output is not stalled; a byte passes the reconstruct stage,
// then the output register. The previous row lives in a single row store of MAX_ROW_BYTES
// bytes: it is read for column k when the byte is taken and written with the reconstructed
// byte one stage later, so each data byte costs at most one read and one write of that
// store. A filter byte above four gives one bad_filter result, and bytes are then dropped
// until frame_start. Row store contents are undefined after reset; the first row of a
// frame never reads them.
// Configuration writes are always taken but should only be made while the block is idle.
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES = 8192
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    png_unf_cfg_if.sink         i_cfg,
    png_unf_in_if.sink          i_in,
    png_unf_out_if.source       o_pix
);

    localparam int CW  = $clog2(MAX_ROW_BYTES + 1);
    localparam int AW  = $clog2(MAX_ROW_BYTES);
    localparam int RW  = ((CW > png_unf_pkg::CFG_DATA_W) ? CW : png_unf_pkg::CFG_DATA_W) + 1;
    localparam logic [RW-1:0] MAX_RB = RW'(MAX_ROW_BYTES);

    // configuration
    logic [png_unf_pkg::CFG_DATA_W-1:0] r_row_bytes;
    logic [2:0]                         r_bpp;

    // row control state
    logic [CW-1:0]           r_col, n_col;
    logic [1:0]              r_mod3, n_mod3;
    png_unf_pkg::t_filter    r_filter, n_filter;
    logic                    r_await, n_await;
    logic                    r_first, n_first;
    logic                    r_halt, n_halt;

    // reconstruct stage
    logic                    r_a_valid;
    png_unf_pkg::t_item      r_a_item;
    logic [CW-1:0]           r_a_col;
    logic [7:0]              r_a_byte;
    logic [7:0]              r_rd;
    logic [31:0]             r_left;
    logic [31:0]             r_ul;

    // output register
    logic                    r_o_valid;
    logic [7:0]              r_o_pixel;
    logic [1:0]              r_o_channel;
    logic                    r_o_eor;
    logic                    r_o_bad;

    logic [7:0]              r_row_mem [MAX_ROW_BYTES];

    logic [RW-1:0]           w_rb_x;
    logic [CW-1:0]           w_rb;
    logic                    w_bpp4;
    logic                    w_in_acc;
    logic                    w_a_fire;
    logic                    w_item_vld;
    png_unf_pkg::t_item      w_item;
    logic [CW-1:0]           w_cur_col;
    logic [1:0]              w_ch;
    logic                    w_re;
    logic                    w_we;
    logic [7:0]              w_a;
    logic [7:0]              w_b;
    logic [7:0]              w_c;
    logic [7:0]              w_pred;
    logic [7:0]              w_val;
    logic                    w_res;

    // effective row length and pixel size
    always_comb begin
        w_rb_x = RW'(r_row_bytes);
        if (w_rb_x == '0) begin
            w_rb_x = RW'(1);
        end else if (w_rb_x > MAX_RB) begin
            w_rb_x = MAX_RB;
        end
    end
    assign w_rb   = w_rb_x[CW-1:0];
    assign w_bpp4 = (r_bpp >= 3'd4);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= png_unf_pkg::CFG_DATA_W'(3);
            r_bpp       <= 3'd3;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                png_unf_pkg::REG_ROW_BYTES: r_row_bytes <= i_cfg.data;
                png_unf_pkg::REG_BPP:       r_bpp       <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

    // handshakes
    assign w_a_fire    = r_a_valid && (!r_o_valid || o_pix.ready);
    assign i_in.ready  = !r_a_valid || w_a_fire;
    assign w_in_acc    = i_in.valid && i_in.ready;

    // row sequencing for the byte on the input
    always_comb begin
        n_col      = r_col;
        n_mod3     = r_mod3;
        n_filter   = r_filter;
        n_await    = r_await;
        n_first    = r_first;
        n_halt     = r_halt;
        w_item_vld = 1'b0;
        w_item     = '0;
        w_cur_col  = r_col;
        w_ch       = 2'd0;
        if (i_in.frame_start) begin
            n_halt  = 1'b0;
            n_first = 1'b1;
            n_await = 1'b1;
            n_col   = '0;
            n_mod3  = 2'd0;
        end
        if (!n_halt) begin
            // row over, also when the row length shrank under the column
            if (!n_await && n_col >= w_rb) begin
                n_await = 1'b1;
                n_first = 1'b0;
            end
            w_item_vld = 1'b1;
            if (n_await) begin
                n_col  = '0;
                n_mod3 = 2'd0;
                if (i_in.data_byte > {5'd0, png_unf_pkg::FLT_PAETH}) begin
                    n_halt    = 1'b1;
                    w_item.op = png_unf_pkg::OP_ERR;
                end else begin
                    n_filter  = i_in.data_byte[2:0];
                    n_await   = 1'b0;
                    w_item.op = png_unf_pkg::OP_CLR;
                end
            end else begin
                w_cur_col        = n_col;
                w_ch             = w_bpp4 ? n_col[1:0] : n_mod3;
                w_item.op        = png_unf_pkg::OP_DATA;
                w_item.filter    = n_filter;
                w_item.first_row = n_first;
                w_item.ch        = w_ch;
                if (w_bpp4) begin
                    w_item.last = (({1'b0, n_col} + 1'b1 == {1'b0, w_rb}) && w_ch != 2'd3) ||
                                  (({1'b0, n_col} + 2'd2 == {1'b0, w_rb}) && w_ch == 2'd2);
                end else begin
                    w_item.last = ({1'b0, n_col} + 1'b1 == {1'b0, w_rb});
                end
                n_col  = n_col + 1'b1;
                n_mod3 = (n_mod3 == 2'd2) ? 2'd0 : n_mod3 + 2'd1;
                if (n_col >= w_rb) begin
                    n_await = 1'b1;
                    n_first = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_mod3   <= 2'd0;
            r_filter <= png_unf_pkg::FLT_NONE;
            r_await  <= 1'b1;
            r_first  <= 1'b1;
            r_halt   <= 1'b0;
        end else if (w_in_acc) begin
            r_col    <= n_col;
            r_mod3   <= n_mod3;
            r_filter <= n_filter;
            r_await  <= n_await;
            r_first  <= n_first;
            r_halt   <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_a_valid <= w_item_vld;
        end else if (w_a_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_item <= w_item;
            r_a_col  <= w_cur_col;
            r_a_byte <= i_in.data_byte;
        end
    end

    // row store: upper byte read on transfer, reconstructed byte written back one stage later
    assign w_re = w_in_acc && w_item_vld && w_item.op == png_unf_pkg::OP_DATA &&
                  !w_item.first_row;
    assign w_we = w_a_fire && r_a_item.op == png_unf_pkg::OP_DATA;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 8'd0;
        end else if (w_re) begin
            r_rd <= r_row_mem[w_cur_col[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_row_mem[r_a_col[AW-1:0]] <= w_val;
        end
    end

    // reconstruct
    assign w_a = w_bpp4 ? r_left[31:24] : r_left[23:16];
    assign w_c = w_bpp4 ? r_ul[31:24]   : r_ul[23:16];
    assign w_b = r_a_item.first_row ? 8'd0 : r_rd;

    png_unf_pred u_pred (
        .i_filter (r_a_item.filter),
        .i_a      (w_a),
        .i_b      (w_b),
        .i_c      (w_c),
        .o_pred   (w_pred)
    );

    assign w_val = w_pred + r_a_byte;

    assign w_res = (r_a_item.op == png_unf_pkg::OP_ERR) ||
                   (r_a_item.op == png_unf_pkg::OP_DATA && r_a_item.ch != 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_ul   <= '0;
        end else if (w_a_fire) begin
            if (r_a_item.op == png_unf_pkg::OP_DATA) begin
                r_left <= {r_left[23:0], w_val};
                r_ul   <= {r_ul[23:0], w_b};
            end else begin
                r_left <= '0;
                r_ul   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_a_fire) begin
            r_o_valid <= w_res;
        end else if (o_pix.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_fire && w_res) begin
            if (r_a_item.op == png_unf_pkg::OP_ERR) begin
                r_o_pixel   <= 8'd0;
                r_o_channel <= 2'd0;
                r_o_eor     <= 1'b0;
                r_o_bad     <= 1'b1;
            end else begin
                r_o_pixel   <= w_val;
                r_o_channel <= r_a_item.ch;
                r_o_eor     <= r_a_item.last;
                r_o_bad     <= 1'b0;
            end
        end
    end

    assign o_pix.valid      = r_o_valid;
    assign o_pix.pixel_byte = r_o_pixel;
    assign o_pix.channel    = r_o_channel;
    assign o_pix.end_of_row = r_o_eor;
    assign o_pix.bad_filter = r_o_bad;

    // upper byte must hold while the reconstruct stage waits
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !w_a_fire) |=> $stable(r_rd))
        else $error("row store read data changed under a stalled byte");

    // a byte taken while halted never reaches the reconstruct stage
    a_halt_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_halt && !i_in.frame_start) |=> !r_a_valid)
        else $error("byte passed while halted on a bad filter");

    // read and write-back never hit the same row store entry in one cycle
    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_re && w_we) |-> (w_cur_col != r_a_col))
        else $error("row store read and write collide");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(MAX_ROW_BYTES))
        else $error("column beyond row store depth");

endmodule

/* verif/tb.sv */
// self-checking testbench of the png scanline unfilter: directed and random byte streams against a predictor
`timescale 1ns / 1ps

module tb;

    localparam int ROW_STORE_DEPTH = 8192;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int IDLE_SETTLE     = 8;
    localparam logic [7:0] BAD_FILTER_LOW = 8'(png_unf_pkg::FLT_PAETH) + 8'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_scan_byte;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [1:0] channel;
        logic       end_of_row;
        logic       bad_filter;
    } t_rgb_sample;

    logic i_clk = 1'b0;
    logic i_rst_n;

    png_unf_cfg_if cfg_ch ();
    png_unf_in_if  in_ch ();
    png_unf_out_if pix_ch ();

    png_scanline_unfilter #(
        .MAX_ROW_BYTES(ROW_STORE_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_pix   (pix_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_scan_byte  pending_bytes [$];
    t_rgb_sample expected_pixels [$];
    int          mismatch_count = 0;
    int          in_gap_max = 11;
    int          out_stall_max = 11;

    // predictor state
    logic [13:0]          row_bytes_cfg = 14'd3;
    logic [2:0]           bpp_cfg = 3'd3;
    logic [7:0]           row_mem [ROW_STORE_DEPTH];
    logic [31:0]          left_hist = '0;
    logic [31:0]          upleft_hist = '0;
    int unsigned          col = 0;
    png_unf_pkg::t_filter cur_filter = png_unf_pkg::FLT_NONE;
    logic                 want_filter = 1'b1;
    logic                 first_row = 1'b1;
    logic                 halted = 1'b0;

    function automatic int clamp_row_len(input int v);
        if (v == 0) return 1;
        if (v > ROW_STORE_DEPTH) return ROW_STORE_DEPTH;
        return v;
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int p, da, db, dc;
        p  = int'(a) + int'(b) - int'(c);
        da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
        db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
        dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    // reconstructs one accepted byte and queues the sample it yields, if any
    task automatic unfilter_byte(input logic [7:0] din, input logic fs);
        int unsigned rb, bpp, sh, ch, r, last_rgb;
        logic [7:0]  a, b, c, pred, val;
        rb  = clamp_row_len(int'(row_bytes_cfg));
        bpp = (bpp_cfg < 3) ? 3 : (bpp_cfg > 4) ? 4 : bpp_cfg;
        sh  = 8 * (bpp - 1);
        if (fs) begin
            halted = 1'b0;
            first_row = 1'b1;
            want_filter = 1'b1;
            col = 0;
        end
        if (halted) return;
        // row length shrunk under a row in progress
        if (!want_filter && col >= rb) begin
            want_filter = 1'b1;
            first_row = 1'b0;
        end
        if (want_filter) begin
            left_hist = '0;
            upleft_hist = '0;
            col = 0;
            if (din > 8'(png_unf_pkg::FLT_PAETH)) begin
                halted = 1'b1;
                expected_pixels.insert(expected_pixels.size(),
                    t_rgb_sample'{pixel_byte: 8'd0, channel: 2'd0,
                                  end_of_row: 1'b0, bad_filter: 1'b1});
                return;
            end
            cur_filter = din[2:0];
            want_filter = 1'b0;
            return;
        end
        a = 8'(left_hist >> sh);
        b = first_row ? 8'd0 : row_mem[col];
        c = 8'(upleft_hist >> sh);
        case (cur_filter)
            png_unf_pkg::FLT_SUB:   pred = a;
            png_unf_pkg::FLT_UP:    pred = b;
            png_unf_pkg::FLT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
            png_unf_pkg::FLT_PAETH: pred = paeth_pick(a, b, c);
            default:                pred = 8'd0;
        endcase
        val = din + pred;
        row_mem[col] = val;
        left_hist = {left_hist[23:0], val};
        upleft_hist = {upleft_hist[23:0], b};
        ch = col % bpp;
        r = (rb - 1) % bpp;
        last_rgb = (r < 3) ? rb - 1 : rb - 1 - (r - 2);
        // alpha bytes give no sample
        if (ch < 3)
            expected_pixels.insert(expected_pixels.size(),
                t_rgb_sample'{pixel_byte: val, channel: ch[1:0],
                              end_of_row: (col == last_rgb), bad_filter: 1'b0});
        col = col + 1;
        if (col >= rb) begin
            want_filter = 1'b1;
            first_row = 1'b0;
        end
    endtask

    // byte stream driver
    t_scan_byte nxt_byte;
    int         in_wait = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                unfilter_byte(in_ch.data_byte, in_ch.frame_start);
            if (!in_ch.valid || in_ch.ready) begin
                if (in_wait > 0) begin
                    in_wait--;
                    in_ch.valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    nxt_byte = pending_bytes.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= nxt_byte.data_byte;
                    in_ch.frame_start <= nxt_byte.frame_start;
                    in_wait = $urandom_range(0, in_gap_max);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // sample monitor and checker
    t_rgb_sample want_pix;
    int          out_stall = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.ready <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result: pixel_byte %0d channel %0d bad_filter %0b",
                           pix_ch.pixel_byte, pix_ch.channel, pix_ch.bad_filter);
                    mismatch_count++;
                end else begin
                    want_pix = expected_pixels.pop_front();
                    if (pix_ch.pixel_byte !== want_pix.pixel_byte) begin
                        $error("pixel_byte: expected %0d, got %0d",
                               want_pix.pixel_byte, pix_ch.pixel_byte);
                        mismatch_count++;
                    end
                    if (pix_ch.channel !== want_pix.channel) begin
                        $error("channel: expected %0d, got %0d",
                               want_pix.channel, pix_ch.channel);
                        mismatch_count++;
                    end
                    if (pix_ch.end_of_row !== want_pix.end_of_row) begin
                        $error("end_of_row: expected %0b, got %0b",
                               want_pix.end_of_row, pix_ch.end_of_row);
                        mismatch_count++;
                    end
                    if (pix_ch.bad_filter !== want_pix.bad_filter) begin
                        $error("bad_filter: expected %0b, got %0b",
                               want_pix.bad_filter, pix_ch.bad_filter);
                        mismatch_count++;
                    end
                end
                out_stall = $urandom_range(0, out_stall_max);
            end
            if (out_stall > 0) begin
                out_stall--;
                pix_ch.ready <= 1'b0;
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("png_scanline_unfilter test failed");
            $finish;
        end
    end

    function automatic int pick_gap_max();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 11;
            default: return $urandom_range(1, 11);
        endcase
    endfunction

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_filter();
        if ($urandom_range(0, 99) < 5)
            return 8'($urandom_range(BAD_FILTER_LOW, 255));
        return 8'($urandom_range(png_unf_pkg::FLT_NONE, png_unf_pkg::FLT_PAETH));
    endfunction

    task automatic push_byte(input logic [7:0] d, input logic fs);
        pending_bytes.insert(pending_bytes.size(), t_scan_byte'{data_byte: d, frame_start: fs});
    endtask

    task automatic push_row(input logic [7:0] filt, input int len, input logic fs);
        push_byte(filt, fs);
        repeat (len) push_byte(rand_sample(), 1'b0);
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_ch.valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        // alpha and filter bytes may still be in flight with no result behind them
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [png_unf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [png_unf_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        if (idx == png_unf_pkg::REG_ROW_BYTES)
            row_bytes_cfg = value;
        else if (idx == png_unf_pkg::REG_BPP)
            bpp_cfg = value[2:0];
    endtask

    task automatic set_config(input int rb_val, input int bpp_val);
        wait_idle();
        write_reg(png_unf_pkg::REG_ROW_BYTES, png_unf_pkg::CFG_DATA_W'(rb_val));
        // upper data bits are don't care for the pixel size
        write_reg(png_unf_pkg::REG_BPP,
                  png_unf_pkg::CFG_DATA_W'(bpp_val | ($urandom_range(0, 2047) << 3)));
    endtask

    // every phase opens a frame, so no row ever reads a store entry it did not write
    task automatic run_phase(input int rb_val, input int bpp_val, input int n_bytes);
        int len, start, kind, i, n;
        len = clamp_row_len(rb_val);
        set_config(rb_val, bpp_val);
        in_gap_max = pick_gap_max();
        out_stall_max = pick_gap_max();
        start = pending_bytes.size();
        push_row(pick_filter(), len, 1'b1);
        while (pending_bytes.size() - start < n_bytes) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    push_row(pick_filter(), len, i == 0);
            end else if (kind < 90) begin
                // frame cut short inside its first row
                push_row(pick_filter(), $urandom_range(0, len - 1), 1'b1);
            end else begin
                repeat ($urandom_range(1, 8))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.frame_start = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        pix_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every filter at reset geometry, then bad filter bytes
        push_byte(8'(png_unf_pkg::FLT_NONE), 1'b1);
        push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b0);
        push_byte(8'(png_unf_pkg::FLT_UP), 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h80, 1'b0);
        push_byte(8'(png_unf_pkg::FLT_SUB), 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'(png_unf_pkg::FLT_AVG), 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
        push_byte(8'(png_unf_pkg::FLT_PAETH), 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b0);
        push_byte(BAD_FILTER_LOW, 1'b0);
        push_byte(8'h07, 1'b0); push_byte(8'h09, 1'b0);
        push_byte(8'hFF, 1'b1);

        // row length shrunk while a row is half done
        set_config(12, 4);
        push_row(8'(png_unf_pkg::FLT_NONE), 12, 1'b1);
        push_row(8'(png_unf_pkg::FLT_PAETH), 7, 1'b0);
        set_config(5, 4);
        push_row(pick_filter(), 5, 1'b0);
        push_row(pick_filter(), 5, 1'b0);

        // row length clamped to the store depth, frames cut short at full rate
        set_config(16383, 4);
        in_gap_max = 0;
        out_stall_max = 0;
        push_row(8'(png_unf_pkg::FLT_SUB), 48, 1'b1);
        push_row(8'(png_unf_pkg::FLT_PAETH), 16, 1'b1);

        run_phase(0, 3, 70);
        run_phase(1, 0, 70);
        run_phase(2, 7, 70);
        run_phase(5, 4, 70);
        run_phase(7, 4, 70);
        run_phase(8, 4, 70);
        run_phase(6, 3, 70);
        repeat (9)
            run_phase($urandom_range(1, 40), $urandom_range(0, 7), 70);

        wait_idle();
        if (mismatch_count == 0)
            $display("png_scanline_unfilter test passed");
        else
            $display("png_scanline_unfilter test failed");
        $finish;
    end

endmodule
